// ----- src/fbrle_pkg.sv -----
// shared types and constants of the glyph rle decoder
`default_nettype none
package fbrle_pkg;

  localparam int ByteBits   = 8;
  localparam int ValueBits  = 8;
  localparam int LenBits    = 6;
  localparam int WidthBits  = 4;
  localparam int FillBits   = 4;
  localparam int RepBits    = 4;
  localparam int IdxBits    = 3;

  localparam logic [RepBits-1:0]   RepeatLimit = 4'd11;
  localparam logic [FillBits-1:0]  CountBits   = 4'd6;
  localparam logic [WidthBits-1:0] WidthReset  = 4'd4;
  localparam logic [WidthBits-1:0] WidthMax    = 4'd8;
  localparam logic [WidthBits-1:0] WidthMin    = 4'd1;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_REPEAT = 2'd1,
    MODE_COUNT  = 2'd2,
    MODE_AFTER  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic push;
    logic push_last;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic pend_valid;
    logic out_free;
    logic bit_last;
  } status_t;

endpackage
`default_nettype wire

// ----- src/fbrle_ctrl.sv -----
// controller: sequences the eight bits of one request and drains the held run
`default_nettype none
module fbrle_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire fbrle_pkg::status_t st,
  output fbrle_pkg::cmd_t       cmd
);

  fbrle_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbrle_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fbrle_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = fbrle_pkg::ST_RUN;
      end
      fbrle_pkg::ST_RUN: begin
        if (!(st.emit && st.pend_valid && !st.out_free) && st.bit_last) begin
          state_next = fbrle_pkg::ST_FLUSH;
        end
      end
      fbrle_pkg::ST_FLUSH: begin
        if (!st.pend_valid || st.out_free) state_next = fbrle_pkg::ST_IDLE;
      end
      default: state_next = fbrle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      fbrle_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      fbrle_pkg::ST_RUN: begin
        // hold the bit when a second run is due and the output is still full
        if (!(st.emit && st.pend_valid && !st.out_free)) begin
          cmd.step = 1'b1;
          cmd.push = st.emit && st.pend_valid;
        end
      end
      fbrle_pkg::ST_FLUSH: begin
        cmd.push      = st.pend_valid && st.out_free;
        cmd.push_last = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/fbrle_dp.sv -----
// datapath: bit decoder state, held run and output register
`default_nettype none
module fbrle_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           s_tdata,
  input  wire logic                 s_tuser,
  input  wire logic                 cfg_valid,
  input  wire logic [3:0]           cfg_data,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [15:0]               m_tdata,
  output logic                      m_tlast,
  input  wire fbrle_pkg::cmd_t      cmd,
  output fbrle_pkg::status_t        st
);

  logic [fbrle_pkg::WidthBits-1:0] bpp;
  logic [fbrle_pkg::ByteBits-1:0]  shreg;
  logic [fbrle_pkg::IdxBits-1:0]   bit_idx;

  fbrle_pkg::mode_t                mode, mode_next;
  logic [fbrle_pkg::ValueBits-1:0] prev, prev_next;
  logic [fbrle_pkg::RepBits-1:0]   rcnt, rcnt_next;
  logic [fbrle_pkg::ValueBits-1:0] acc, acc_next;
  logic [fbrle_pkg::FillBits-1:0]  fill, fill_next;
  logic                            started, started_next;

  logic                            pend_valid;
  logic [fbrle_pkg::ValueBits-1:0] pend_val;
  logic [fbrle_pkg::LenBits-1:0]   pend_len;
  logic [fbrle_pkg::ValueBits-1:0] out_val;
  logic [fbrle_pkg::LenBits-1:0]   out_len;

  logic                            cur_bit;
  logic [fbrle_pkg::WidthBits-1:0] w;
  logic [fbrle_pkg::ValueBits-1:0] mask;
  logic [fbrle_pkg::ValueBits-1:0] acc_sh;
  logic [fbrle_pkg::FillBits-1:0]  fill_inc;
  logic [fbrle_pkg::RepBits-1:0]   rcnt_inc;
  logic [fbrle_pkg::ValueBits-1:0] lit;
  logic                            emit;
  logic [fbrle_pkg::ValueBits-1:0] run_val;
  logic [fbrle_pkg::LenBits-1:0]   run_len;

  assign cur_bit  = shreg[fbrle_pkg::ByteBits-1];
  assign fill_inc = fill + 4'd1;
  assign rcnt_inc = rcnt + 4'd1;

  // clamp the literal width to 1..8
  always_comb begin
    if (bpp == '0) begin
      w = fbrle_pkg::WidthMin;
    end else if (bpp > fbrle_pkg::WidthMax) begin
      w = fbrle_pkg::WidthMax;
    end else begin
      w = bpp;
    end
  end

  assign mask = 8'hFF >> (fbrle_pkg::WidthMax - w);
  assign lit  = acc_sh & mask;

  always_comb begin
    mode_next    = mode;
    prev_next    = prev;
    rcnt_next    = rcnt;
    acc_next     = acc;
    fill_next    = fill;
    started_next = started;
    emit         = 1'b0;
    run_val      = prev;
    run_len      = 6'd1;
    acc_sh       = {acc[6:0], cur_bit};
    case (mode)
      fbrle_pkg::MODE_SINGLE, fbrle_pkg::MODE_AFTER: begin
        if (fill_inc >= w) begin
          emit         = 1'b1;
          run_val      = lit;
          prev_next    = lit;
          started_next = 1'b1;
          acc_next     = '0;
          fill_next    = '0;
          rcnt_next    = '0;
          // only a plain literal equal to the last one opens repeat mode
          if (mode == fbrle_pkg::MODE_SINGLE && started && lit == prev) begin
            mode_next = fbrle_pkg::MODE_REPEAT;
          end else begin
            mode_next = fbrle_pkg::MODE_SINGLE;
          end
        end else begin
          acc_next  = acc_sh;
          fill_next = fill_inc;
        end
      end
      fbrle_pkg::MODE_REPEAT: begin
        if (cur_bit) begin
          if (rcnt_inc >= fbrle_pkg::RepeatLimit) begin
            rcnt_next = '0;
            acc_next  = '0;
            fill_next = '0;
            mode_next = fbrle_pkg::MODE_COUNT;
          end else begin
            rcnt_next = rcnt_inc;
            emit      = 1'b1;
          end
        end else begin
          rcnt_next = '0;
          acc_next  = '0;
          fill_next = '0;
          mode_next = fbrle_pkg::MODE_AFTER;
        end
      end
      fbrle_pkg::MODE_COUNT: begin
        acc_sh = {2'b00, acc[4:0], cur_bit};
        if (fill_inc >= fbrle_pkg::CountBits) begin
          run_len   = acc_sh[fbrle_pkg::LenBits-1:0];
          emit      = (acc_sh[fbrle_pkg::LenBits-1:0] != '0);
          acc_next  = '0;
          fill_next = '0;
          mode_next = fbrle_pkg::MODE_AFTER;
        end else begin
          acc_next  = acc_sh;
          fill_next = fill_inc;
        end
      end
      default: begin
        mode_next = fbrle_pkg::MODE_SINGLE;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bpp <= fbrle_pkg::WidthReset;
    end else if (cfg_valid) begin
      bpp <= cfg_data;
    end
  end

  // byte shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_idx <= '0;
    end else if (cmd.load) begin
      bit_idx <= '0;
    end else if (cmd.step) begin
      bit_idx <= bit_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg <= s_tdata;
    end else if (cmd.step) begin
      shreg <= {shreg[6:0], 1'b0};
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst || (cmd.load && s_tuser)) begin
      mode    <= fbrle_pkg::MODE_SINGLE;
      prev    <= '0;
      rcnt    <= '0;
      acc     <= '0;
      fill    <= '0;
      started <= 1'b0;
    end else if (cmd.step) begin
      mode    <= mode_next;
      prev    <= prev_next;
      rcnt    <= rcnt_next;
      acc     <= acc_next;
      fill    <= fill_next;
      started <= started_next;
    end
  end

  // held run: waits until it is known whether it ends the byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      pend_val <= run_val;
      pend_len <= run_len;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_val <= pend_val;
      out_len <= pend_len;
      m_tlast <= cmd.push_last;
    end
  end

  assign m_tdata = {2'b00, out_len, out_val};

  assign st.emit       = emit;
  assign st.pend_valid = pend_valid;
  assign st.out_free   = !m_tvalid || m_tready;
  assign st.bit_last   = (bit_idx == 3'd7);

  a_pend_len: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend_len != '0)
    else $error("held run has zero length");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!m_tvalid || m_tready) && pend_valid)
    else $error("push into a busy output or from an empty hold");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    mode == fbrle_pkg::MODE_COUNT |-> rcnt == '0 && fill < fbrle_pkg::CountBits)
    else $error("count mode entered with stale counters");

  a_repeat_cnt: assert property (@(posedge clk) disable iff (rst)
    rcnt < fbrle_pkg::RepeatLimit)
    else $error("repeat counter past its limit");

endmodule
`default_nettype wire

// ----- src/font_bitmap_rle_decoder_core.sv -----
// top level of the glyph rle decoder: controller plus datapath
// path: each decoded run waits in the one-run hold and moves to the output register when the
//   next run is decoded or, for the byte's last run, in the drain state with m_tlast set
// throughput: one accept, eight bit steps and one drain per byte, one bit
//   per cycle through the decoder; output stalls hold the bit cycle where a second run waits, and the drain
// reset: rst is synchronous and active high; clears decoder state, sets bits_per_pixel to 4
`default_nettype none
module font_bitmap_rle_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] start_of_glyph
  // configuration write: bits_per_pixel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  // decoded runs
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] pixel_value, [13:8] run_length, [15:14] zero
  output logic             m_tlast    // last_of_byte
);

  fbrle_pkg::cmd_t    cmd;
  fbrle_pkg::status_t st;

  // the register takes a write at any cycle
  assign cfg_ready = 1'b1;

  // controller: accept, step through bits, drain the held run with last set
  fbrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: decoder state, one-run hold so the byte's last run can be marked,
  // and the output register that frees the input side
  fbrle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
`default_nettype wire
